// ----- src/tgahdr_pkg.sv -----
// ----------------------------------------------------------------------------
// tgahdr_pkg: shared types and constants for the TGA header check block
// Result kinds, image type codes, header byte positions and the result struct.
// ----------------------------------------------------------------------------
package tgahdr_pkg;

	localparam int DATA_W  = 8;
	localparam int WORD_W  = 32;
	localparam int DIM_W   = 16;
	localparam int KIND_W  = 2;
	localparam int NBYTE_W = 3;
	localparam int HPOS_W  = 5;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_HDR_OK  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_HDR_BAD = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PIXEL   = 2'd2;

	// image type codes
	localparam logic [DATA_W-1:0] TYPE_RGB  = 8'd2;
	localparam logic [DATA_W-1:0] TYPE_GRAY = 8'd3;
	localparam logic [DATA_W-1:0] TYPE_RLE  = 8'd10;

	// header byte positions
	localparam logic [HPOS_W-1:0] HPOS_IDENT  = 5'd0;
	localparam logic [HPOS_W-1:0] HPOS_TYPE   = 5'd2;
	localparam logic [HPOS_W-1:0] HPOS_WID_LO = 5'd12;
	localparam logic [HPOS_W-1:0] HPOS_WID_HI = 5'd13;
	localparam logic [HPOS_W-1:0] HPOS_HGT_LO = 5'd14;
	localparam logic [HPOS_W-1:0] HPOS_HGT_HI = 5'd15;
	localparam logic [HPOS_W-1:0] HPOS_BPP    = 5'd16;
	localparam logic [HPOS_W-1:0] HPOS_LAST   = 5'd17;

	typedef struct packed {
		logic               valid;
		logic [KIND_W-1:0]  kind;
		logic [WORD_W-1:0]  pixel_word;
		logic [NBYTE_W-1:0] pixel_bytes;
		logic [DATA_W-1:0]  image_type;
		logic [DIM_W-1:0]   image_width;
		logic [DIM_W-1:0]   image_height;
		logic [DATA_W-1:0]  bits_per_pixel;
		logic               last_pixel;
	} result_t;

	// bytes per pixel, 0 when the depth is not supported
	function automatic logic [NBYTE_W-1:0] bytes_per_pel(input logic [DATA_W-1:0] bpp);
		logic [4:0] b;
		b = bpp[7:3];
		if (b == 5'd1 || b == 5'd3 || b == 5'd4)
			return b[NBYTE_W-1:0];
		else
			return '0;
	endfunction

endpackage

// ----- src/tgahdr_parse.sv -----
// ----------------------------------------------------------------------------
// tgahdr_parse: header capture, ident skip and pixel gather
// Holds the parse state; computes the next state and the result for one byte.
// ----------------------------------------------------------------------------
module tgahdr_parse (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           advance,
	input  logic [tgahdr_pkg::DATA_W-1:0]  data_byte,
	input  logic                           file_start,
	output tgahdr_pkg::result_t            res
);
	import tgahdr_pkg::*;

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_SKIP   = 2'd1;
	localparam logic [1:0] PH_PIXELS = 2'd2;
	localparam logic [1:0] PH_DONE   = 2'd3;

	logic [1:0]        phase_q, phase_d;
	logic [HPOS_W-1:0] header_pos_q, header_pos_d;
	logic [DATA_W-1:0] ident_len_q, ident_len_d;
	logic [DATA_W-1:0] type_q, type_d;
	logic [DIM_W-1:0]  width_q, width_d;
	logic [DIM_W-1:0]  height_q, height_d;
	logic [DATA_W-1:0] bpp_q, bpp_d;
	logic [DATA_W-1:0] skip_left_q, skip_left_d;
	logic [23:0]       pixel_acc_q, pixel_acc_d;
	logic [1:0]        byte_in_pixel_q, byte_in_pixel_d;
	logic [WORD_W-1:0] pixels_left_q, pixels_left_d;

	logic [1:0]         ph;
	logic [HPOS_W-1:0]  hpos;
	logic [23:0]        acc;
	logic [1:0]         k;
	logic [NBYTE_W-1:0] bpb;
	logic [WORD_W-1:0]  area;
	logic [WORD_W-1:0]  word;
	logic [WORD_W-1:0]  pl_dec;
	logic [DATA_W-1:0]  skip_dec;
	logic               hdr_ok;

	assign bpb  = bytes_per_pel(bpp_q);
	assign area = WORD_W'(width_q) * WORD_W'(height_q);
	assign ph   = file_start ? PH_HEADER : phase_q;
	assign hpos = file_start ? HPOS_IDENT : header_pos_q;
	assign acc  = file_start ? '0 : pixel_acc_q;
	assign k    = file_start ? 2'd0 : byte_in_pixel_q;
	assign word = {8'd0, acc} | (WORD_W'(data_byte) << {k, 3'b000});
	assign pl_dec   = (pixels_left_q != '0) ? pixels_left_q - 1'b1 : '0;
	assign skip_dec = (skip_left_q != '0) ? skip_left_q - 1'b1 : '0;
	assign hdr_ok = (type_q == TYPE_RGB || type_q == TYPE_GRAY || type_q == TYPE_RLE)
		&& width_q != '0 && height_q != '0 && bpb != '0;

	always_comb begin
		phase_d         = ph;
		header_pos_d    = hpos;
		ident_len_d     = ident_len_q;
		type_d          = type_q;
		width_d         = width_q;
		height_d        = height_q;
		bpp_d           = bpp_q;
		skip_left_d     = skip_left_q;
		pixel_acc_d     = acc;
		byte_in_pixel_d = k;
		pixels_left_d   = pixels_left_q;

		res                = '0;
		res.pixel_bytes    = bpb;
		res.image_type     = type_q;
		res.image_width    = width_q;
		res.image_height   = height_q;
		res.bits_per_pixel = bpp_q;

		unique case (ph)
			PH_HEADER: begin
				unique case (hpos)
					HPOS_IDENT:  ident_len_d = data_byte;
					HPOS_TYPE:   type_d = data_byte;
					HPOS_WID_LO: width_d[7:0] = data_byte;
					HPOS_WID_HI: width_d[15:8] = data_byte;
					HPOS_HGT_LO: height_d[7:0] = data_byte;
					HPOS_HGT_HI: height_d[15:8] = data_byte;
					HPOS_BPP:    bpp_d = data_byte;
					default: ;
				endcase
				if (hpos < HPOS_LAST) begin
					header_pos_d = hpos + 1'b1;
				end else begin
					header_pos_d = '0;
					res.valid    = 1'b1;
					res.kind     = hdr_ok ? KIND_HDR_OK : KIND_HDR_BAD;
					if (!hdr_ok || type_q == TYPE_RLE) begin
						phase_d = PH_DONE;
					end else if (ident_len_q != '0) begin
						phase_d     = PH_SKIP;
						skip_left_d = ident_len_q;
					end else begin
						phase_d         = PH_PIXELS;
						pixel_acc_d     = '0;
						byte_in_pixel_d = '0;
						pixels_left_d   = area;
					end
				end
			end
			PH_SKIP: begin
				skip_left_d = skip_dec;
				if (skip_dec == '0) begin
					phase_d         = PH_PIXELS;
					pixel_acc_d     = '0;
					byte_in_pixel_d = '0;
					pixels_left_d   = area;
				end
			end
			PH_PIXELS: begin
				if (bpb == '0) begin
					phase_d = PH_DONE;
				end else begin
					if (k != 2'd3)
						pixel_acc_d = word[23:0];
					if ({1'b0, k} + 3'd1 < bpb) begin
						byte_in_pixel_d = k + 1'b1;
					end else begin
						pixel_acc_d     = '0;
						byte_in_pixel_d = '0;
						pixels_left_d   = pl_dec;
						res.valid       = 1'b1;
						res.kind        = KIND_PIXEL;
						res.last_pixel  = (pl_dec == '0);
						// BGR to RGB for true-color images
						if (type_q == TYPE_RGB && bpb >= 3'd3)
							res.pixel_word = {word[31:24], word[7:0], word[15:8], word[23:16]};
						else
							res.pixel_word = word;
						if (pl_dec == '0)
							phase_d = PH_DONE;
					end
				end
			end
			PH_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_HEADER;
			header_pos_q    <= '0;
			ident_len_q     <= '0;
			type_q          <= '0;
			width_q         <= '0;
			height_q        <= '0;
			bpp_q           <= '0;
			skip_left_q     <= '0;
			pixel_acc_q     <= '0;
			byte_in_pixel_q <= '0;
			pixels_left_q   <= '0;
		end else if (advance) begin
			phase_q         <= phase_d;
			header_pos_q    <= header_pos_d;
			ident_len_q     <= ident_len_d;
			type_q          <= type_d;
			width_q         <= width_d;
			height_q        <= height_d;
			bpp_q           <= bpp_d;
			skip_left_q     <= skip_left_d;
			pixel_acc_q     <= pixel_acc_d;
			byte_in_pixel_q <= byte_in_pixel_d;
			pixels_left_q   <= pixels_left_d;
		end
	end

endmodule

// ----- src/tga_header_check_pixel_unpack.sv -----
// ----------------------------------------------------------------------------
// tga_header_check_pixel_unpack: TGA header check and pixel unpack
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------
//   in      | input     | in_valid/in_stall   | data_byte, file_start
//   out     | output    | out_valid/out_stall | kind, pixel_word, pixel_bytes,
//           |           |                    | image_type, image_width,
//           |           |                    | image_height, bits_per_pixel,
//           |           |                    | last_pixel
//
// One byte per cycle while out_stall does not hold the output register; each result
// passes the input register, then the result register. The path through the parser is
// set by the 16x16 width*height product loaded into the pixel counter.
// Reset clears the parser to header position 0. in_stall rises only while
// a result waits in the output register and out_stall is high.
// ----------------------------------------------------------------------------
module tga_header_check_pixel_unpack (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [tgahdr_pkg::DATA_W-1:0]   data_byte,
	input  logic                            file_start,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [tgahdr_pkg::KIND_W-1:0]   kind,
	output logic [tgahdr_pkg::WORD_W-1:0]   pixel_word,
	output logic [tgahdr_pkg::NBYTE_W-1:0]  pixel_bytes,
	output logic [tgahdr_pkg::DATA_W-1:0]   image_type,
	output logic [tgahdr_pkg::DIM_W-1:0]    image_width,
	output logic [tgahdr_pkg::DIM_W-1:0]    image_height,
	output logic [tgahdr_pkg::DATA_W-1:0]   bits_per_pixel,
	output logic                            last_pixel
);
	import tgahdr_pkg::*;

	logic              valid_s1;
	logic [DATA_W-1:0] data_byte_s1;
	logic              file_start_s1;
	logic              advance;
	logic              out_valid_q;
	result_t           res;
	result_t           res_q;

	// s1 moves on whenever the output register is empty or being drained
	assign advance  = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			data_byte_s1  <= data_byte;
			file_start_s1 <= file_start;
		end
	end

	tgahdr_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.data_byte  (data_byte_s1),
		.file_start (file_start_s1),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= res.valid;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid)
			res_q <= res;
	end

	assign out_valid      = out_valid_q;
	assign kind           = res_q.kind;
	assign pixel_word     = res_q.pixel_word;
	assign pixel_bytes    = res_q.pixel_bytes;
	assign image_type     = res_q.image_type;
	assign image_width    = res_q.image_width;
	assign image_height   = res_q.image_height;
	assign bits_per_pixel = res_q.bits_per_pixel;
	assign last_pixel     = res_q.last_pixel;

	// pixel transactions only ever carry a supported depth
	a_pixel_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_PIXEL) |->
		(pixel_bytes == 3'd1 || pixel_bytes == 3'd3 || pixel_bytes == 3'd4))
		else $error("pixel transaction with unsupported depth");

	a_hdr_ok_dims: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_HDR_OK) |->
		(image_width != '0 && image_height != '0 &&
		 (image_type == TYPE_RGB || image_type == TYPE_GRAY || image_type == TYPE_RLE)))
		else $error("accepted header with bad fields");

	a_last_is_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_pixel) |-> (kind == KIND_PIXEL))
		else $error("last flag on a header transaction");

	a_no_rle_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_PIXEL) |-> (image_type != TYPE_RLE))
		else $error("pixel emitted for run-length image");

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench for tga_header_check_pixel_unpack
// Streams TGA files byte by byte: directed headers and pixel layouts first,
// then random files, broken files and noise. A predictor tracks the parse and
// queues the expected header and pixel results. Each result is checked field
// by field against the oldest queued one. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
	import tgahdr_pkg::*;

	localparam int TARGET_BYTES = 900;
	localparam int IDLE_LIMIT   = 3000;
	localparam int RX_HOLD      = 300;
	localparam int HOLD_AT      = 150;
	localparam int MAX_WAIT     = 12;
	localparam int PRINT_CAP    = 40;

	typedef enum logic [1:0] {
		PARSE_HEADER,
		PARSE_SKIP,
		PARSE_PIXELS,
		PARSE_DONE
	} parse_phase_e;

	typedef struct {
		logic [DATA_W-1:0] data;
		logic              start;
		logic              drain;
	} stream_byte_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [WORD_W-1:0]  pixel_word;
		logic [NBYTE_W-1:0] pixel_bytes;
		logic [DATA_W-1:0]  image_type;
		logic [DIM_W-1:0]   image_width;
		logic [DIM_W-1:0]   image_height;
		logic [DATA_W-1:0]  bits_per_pixel;
		logic               last_pixel;
	} tga_out_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_stall;
	logic [DATA_W-1:0]   data_byte  = '0;
	logic                file_start = 1'b0;
	logic                out_valid;
	logic                out_stall  = 1'b0;
	logic [KIND_W-1:0]   kind;
	logic [WORD_W-1:0]   pixel_word;
	logic [NBYTE_W-1:0]  pixel_bytes;
	logic [DATA_W-1:0]   image_type;
	logic [DIM_W-1:0]    image_width;
	logic [DIM_W-1:0]    image_height;
	logic [DATA_W-1:0]   bits_per_pixel;
	logic                last_pixel;

	// pending file bytes and results the parser should produce
	stream_byte_t byte_q[$];
	tga_out_t     expected_out[$];

	int n_queued   = 0;
	int n_accepted = 0;
	int n_results  = 0;
	int n_errors   = 0;
	int n_hdr_ok   = 0;
	int n_hdr_bad  = 0;
	int n_pixels   = 0;
	int n_drains   = 0;

	// parser state as predicted
	parse_phase_e      p_phase  = PARSE_HEADER;
	logic [HPOS_W-1:0] p_hpos   = '0;
	logic [7:0]        p_ident  = '0;
	logic [7:0]        p_type   = '0;
	logic [15:0]       p_width  = '0;
	logic [15:0]       p_height = '0;
	logic [7:0]        p_bpp    = '0;
	logic [7:0]        p_skip   = '0;
	logic [23:0]       p_acc    = '0;
	logic [1:0]        p_bidx   = '0;
	logic [31:0]       p_left   = '0;

	// sender and receiver pacing
	int           tx_gap   = 0;
	bit           tx_burst = 1'b0;
	stream_byte_t tx_item;
	logic         tx_next_valid;
	int           rx_wait  = 0;
	int           rx_hold  = 0;
	bit           rx_burst = 1'b0;
	bit           rx_held  = 1'b0;
	tga_out_t     rx_want;
	int           idle_cycles = 0;

	tga_header_check_pixel_unpack uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.file_start    (file_start),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.pixel_word    (pixel_word),
		.pixel_bytes   (pixel_bytes),
		.image_type    (image_type),
		.image_width   (image_width),
		.image_height  (image_height),
		.bits_per_pixel(bits_per_pixel),
		.last_pixel    (last_pixel)
	);

	// bytes per pixel for a depth byte; 0 when the depth is unsupported
	function automatic logic [2:0] pel_bytes(input logic [7:0] bpp);
		case (bpp[7:3])
		5'd1, 5'd3, 5'd4: return bpp[5:3];
		default: return 3'd0;
		endcase
	endfunction

	function automatic tga_out_t make_out(input logic [KIND_W-1:0] k,
			input logic [31:0] word, input logic is_last);
		tga_out_t r;
		r.kind           = k;
		r.pixel_word     = word;
		r.pixel_bytes    = pel_bytes(p_bpp);
		r.image_type     = p_type;
		r.image_width    = p_width;
		r.image_height   = p_height;
		r.bits_per_pixel = p_bpp;
		r.last_pixel     = is_last;
		return r;
	endfunction

	function automatic void start_pixels();
		p_phase = PARSE_PIXELS;
		p_acc   = '0;
		p_bidx  = '0;
		p_left  = 32'(p_width) * 32'(p_height);
	endfunction

	function automatic void predict_byte(input logic [7:0] d, input logic s);
		logic [2:0]  bpb;
		logic [31:0] word;
		logic        ok;
		logic        is_last;
		if (s) begin
			p_phase = PARSE_HEADER;
			p_hpos  = '0;
			p_acc   = '0;
			p_bidx  = '0;
		end
		case (p_phase)
		PARSE_HEADER: begin
			case (p_hpos)
			HPOS_IDENT:  p_ident = d;
			HPOS_TYPE:   p_type = d;
			HPOS_WID_LO: p_width[7:0] = d;
			HPOS_WID_HI: p_width[15:8] = d;
			HPOS_HGT_LO: p_height[7:0] = d;
			HPOS_HGT_HI: p_height[15:8] = d;
			HPOS_BPP:    p_bpp = d;
			default: ;
			endcase
			if (p_hpos < HPOS_LAST) begin
				p_hpos = p_hpos + 1'b1;
				return;
			end
			bpb = pel_bytes(p_bpp);
			ok = (p_type == TYPE_RGB || p_type == TYPE_GRAY || p_type == TYPE_RLE) &&
				p_width != 0 && p_height != 0 && bpb != 0;
			p_hpos = '0;
			expected_out.push_back(make_out(ok ? KIND_HDR_OK : KIND_HDR_BAD, '0, 1'b0));
			if (!ok || p_type == TYPE_RLE) begin
				p_phase = PARSE_DONE;
			end else if (p_ident != 0) begin
				p_phase = PARSE_SKIP;
				p_skip  = p_ident;
			end else begin
				start_pixels();
			end
		end
		PARSE_SKIP: begin
			if (p_skip != 0)
				p_skip = p_skip - 1'b1;
			if (p_skip == 0)
				start_pixels();
		end
		PARSE_PIXELS: begin
			bpb  = pel_bytes(p_bpp);
			word = {8'h00, p_acc} | (32'(d) << (8 * p_bidx));
			if (bpb == 0) begin
				p_phase = PARSE_DONE;
				return;
			end
			if (p_bidx < 3)
				p_acc = word[23:0];
			if (p_bidx + 1 < bpb) begin
				p_bidx = p_bidx + 1'b1;
				return;
			end
			// color files store BGR(A); swap first and third byte
			if (p_type == TYPE_RGB && bpb >= 3)
				word = {word[31:24], word[7:0], word[15:8], word[23:16]};
			p_acc  = '0;
			p_bidx = '0;
			if (p_left != 0)
				p_left = p_left - 1;
			is_last = (p_left == 0);
			if (is_last)
				p_phase = PARSE_DONE;
			expected_out.push_back(make_out(KIND_PIXEL, word, is_last));
		end
		default: ;
		endcase
	endfunction

	// header fields go to their positions, all other header bytes are random
	function automatic void queue_file(input bit start_flag, input logic [7:0] itype,
			input logic [15:0] w, input logic [15:0] h, input logic [7:0] bpp,
			input logic [7:0] ident, input int hdr_len, input int body_len);
		logic [7:0] b;
		for (int i = 0; i < hdr_len; i++) begin
			b = 8'($urandom_range(0, 255));
			case (i)
			HPOS_IDENT:  b = ident;
			HPOS_TYPE:   b = itype;
			HPOS_WID_LO: b = w[7:0];
			HPOS_WID_HI: b = w[15:8];
			HPOS_HGT_LO: b = h[7:0];
			HPOS_HGT_HI: b = h[15:8];
			HPOS_BPP:    b = bpp;
			default: ;
			endcase
			byte_q.push_back('{data: b, start: start_flag && i == 0, drain: 1'b0});
		end
		for (int i = 0; i < body_len; i++)
			byte_q.push_back('{data: 8'($urandom_range(0, 255)), start: 1'b0, drain: 1'b0});
		n_queued += hdr_len + body_len;
	endfunction

	task automatic report_error(input string msg);
		if (n_errors < PRINT_CAP)
			$display("tb: error at %0t: %s", $realtime, msg);
		n_errors++;
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			data_byte  <= '0;
			file_start <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_byte(data_byte, file_start);
				n_accepted++;
				tx_gap = tx_burst ? 0 : $urandom_range(0, MAX_WAIT);
				if ($urandom_range(0, 49) == 0)
					tx_burst = !tx_burst;
			end
			if (!in_valid || !in_stall) begin
				tx_next_valid = 1'b0;
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (byte_q.size() != 0 && byte_q[0].drain) begin
					// hold the stream until all results are back
					if (expected_out.size() == 0) begin
						void'(byte_q.pop_front());
						n_drains++;
					end
				end else if (byte_q.size() != 0) begin
					tx_item = byte_q.pop_front();
					data_byte     <= tx_item.data;
					file_start    <= tx_item.start;
					tx_next_valid = 1'b1;
				end
				in_valid <= tx_next_valid;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				n_results++;
				if (expected_out.size() == 0) begin
					report_error($sformatf("result %0d with none expected, kind %0d",
						n_results, kind));
				end else begin
					rx_want = expected_out.pop_front();
					case (rx_want.kind)
					KIND_HDR_OK:  n_hdr_ok++;
					KIND_HDR_BAD: n_hdr_bad++;
					default:      n_pixels++;
					endcase
					if (kind !== rx_want.kind)
						report_error($sformatf("result %0d kind %0d, expected %0d",
							n_results, kind, rx_want.kind));
					if (pixel_word !== rx_want.pixel_word)
						report_error($sformatf("result %0d pixel_word %h, expected %h",
							n_results, pixel_word, rx_want.pixel_word));
					if (pixel_bytes !== rx_want.pixel_bytes)
						report_error($sformatf("result %0d pixel_bytes %0d, expected %0d",
							n_results, pixel_bytes, rx_want.pixel_bytes));
					if (image_type !== rx_want.image_type)
						report_error($sformatf("result %0d image_type %0d, expected %0d",
							n_results, image_type, rx_want.image_type));
					if (image_width !== rx_want.image_width)
						report_error($sformatf("result %0d image_width %0d, expected %0d",
							n_results, image_width, rx_want.image_width));
					if (image_height !== rx_want.image_height)
						report_error($sformatf("result %0d image_height %0d, expected %0d",
							n_results, image_height, rx_want.image_height));
					if (bits_per_pixel !== rx_want.bits_per_pixel)
						report_error($sformatf("result %0d bits_per_pixel %0d, expected %0d",
							n_results, bits_per_pixel, rx_want.bits_per_pixel));
					if (last_pixel !== rx_want.last_pixel)
						report_error($sformatf("result %0d last_pixel %0d, expected %0d",
							n_results, last_pixel, rx_want.last_pixel));
				end
				rx_wait = rx_burst ? 0 : $urandom_range(0, MAX_WAIT);
				if ($urandom_range(0, 49) == 0)
					rx_burst = !rx_burst;
				// one long back-pressure stretch so the block fills and stalls its input
				if (n_results == HOLD_AT && !rx_held) begin
					rx_hold = RX_HOLD;
					rx_held = 1'b1;
				end
			end
			if (rx_hold > 0) begin
				rx_hold--;
				out_stall <= 1'b1;
			end else if (rx_wait > 0) begin
				rx_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: timeout, %0d results still expected", expected_out.size());
				$display("tb: FAIL");
				$finish;
			end
		end
	end

	initial begin
		int          pick;
		int          body;
		logic [7:0]  itype;
		logic [7:0]  bpp;
		logic [7:0]  ident;
		logic [15:0] w;
		logic [15:0] h;

		// directed files; the first one has no start flag after reset
		queue_file(1'b0, TYPE_RGB, 16'd2, 16'd1, 8'd24, 8'd0, 18, 6);
		queue_file(1'b1, TYPE_RGB, 16'd1, 16'd2, 8'd32, 8'd3, 18, 11);
		queue_file(1'b1, TYPE_RGB, 16'd3, 16'd1, 8'd8, 8'd0, 18, 3);     // no swap at 8 bpp
		queue_file(1'b1, TYPE_GRAY, 16'd2, 16'd2, 8'd8, 8'd0, 18, 4);
		queue_file(1'b1, TYPE_GRAY, 16'd1, 16'd1, 8'd24, 8'd1, 18, 4);
		queue_file(1'b1, TYPE_RLE, 16'd4, 16'd4, 8'd24, 8'd0, 18, 5);    // trailing bytes ignored
		queue_file(1'b1, 8'd1, 16'd2, 16'd2, 8'd24, 8'd0, 18, 2);
		queue_file(1'b1, TYPE_RGB, 16'd0, 16'd2, 8'd24, 8'd0, 18, 0);
		queue_file(1'b1, TYPE_RGB, 16'd2, 16'd0, 8'd24, 8'd0, 18, 0);
		queue_file(1'b1, TYPE_RGB, 16'd1, 16'd1, 8'd16, 8'd0, 18, 0);
		queue_file(1'b1, TYPE_GRAY, 16'd1, 16'd1, 8'd7, 8'd0, 18, 0);
		queue_file(1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 18, 0);
		queue_file(1'b1, TYPE_RGB, 16'd1, 16'd2, 8'd39, 8'd0, 18, 8);    // truncated depth
		queue_file(1'b1, TYPE_RLE, 16'hFFFF, 16'hFFFF, 8'd32, 8'hFF, 18, 0);
		// restart inside the pixel data, inside the ident skip and inside the header
		queue_file(1'b1, TYPE_GRAY, 16'hFFFF, 16'hFFFF, 8'd32, 8'd0, 18, 9);
		queue_file(1'b1, TYPE_RGB, 16'd2, 16'd2, 8'd24, 8'd6, 18, 3);
		queue_file(1'b1, TYPE_RGB, 16'd1, 16'd1, 8'd24, 8'd0, 7, 0);
		queue_file(1'b1, TYPE_GRAY, 16'd1, 16'd1, 8'd8, 8'hFF, 18, 256);
		byte_q.push_back('{data: '0, start: 1'b0, drain: 1'b1});

		while (n_queued < TARGET_BYTES) begin
			pick  = $urandom_range(0, 19);
			itype = ($urandom_range(0, 3) == 0) ? TYPE_GRAY : TYPE_RGB;
			if ($urandom_range(0, 9) == 0)
				itype = TYPE_RLE;
			w = 16'($urandom_range(1, 3));
			h = 16'($urandom_range(1, 3));
			if ($urandom_range(0, 15) == 0)
				w = 16'($urandom_range(1, 12));
			case ($urandom_range(0, 2))
			0: bpp = 8'd8;
			1: bpp = 8'd24;
			default: bpp = 8'd32;
			endcase
			bpp[2:0] = 3'($urandom_range(0, 7));
			ident = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 6)) : 8'd0;
			body = (itype == TYPE_RLE) ? $urandom_range(0, 3) :
				ident + w * h * pel_bytes(bpp);
			if (pick < 14)
				queue_file(1'b1, itype, w, h, bpp, ident, 18, body);
			else if (pick < 16)
				queue_file(1'b1, itype, w, h, bpp, ident, 18, $urandom_range(0, body));
			else if (pick < 18)
				queue_file(1'b1, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 18, $urandom_range(0, 4));
			else if (pick == 18)
				queue_file(1'b1, itype, w, h, bpp, ident, $urandom_range(1, 17), 0);
			else
				queue_file(1'b0, itype, w, h, bpp, ident, 18, body);
			if ($urandom_range(0, 39) == 0)
				byte_q.push_back('{data: '0, start: 1'b0, drain: 1'b1});
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (n_accepted != n_queued)
			@(posedge clk);
		while (expected_out.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("tb: %0d bytes streamed, %0d headers accepted, %0d rejected, %0d pixels",
			n_accepted, n_hdr_ok, n_hdr_bad, n_pixels);
		$display("tb: %0d results checked, %0d drain pauses, receiver hold %0d cycles",
			n_results, n_drains, rx_held ? RX_HOLD : 0);
		if (n_errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/tgahdr_pkg.sv
src/tgahdr_parse.sv
src/tga_header_check_pixel_unpack.sv
dv/tb.sv
